// File: hdl/cis_pkg.sv
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types and fixed widths for the capped interpolation search block.
// ----------------------------------------------------------------------------
package cis_pkg;

   // field widths
   localparam int IDX_W   = 13;
   localparam int KEY_W   = 27;

   // datapath widths
   localparam int DIFF_W  = IDX_W + 1;          // signed index difference
   localparam int KDIFF_W = KEY_W + 1;          // signed key difference
   localparam int PROD_W  = DIFF_W + KDIFF_W;   // signed product
   localparam int N2_W    = PROD_W + 2;         // 2*num + den
   localparam int DVD_W   = N2_W - 1;           // dividend magnitude
   localparam int DVS_W   = KDIFF_W + 1;        // divisor magnitude (2*|den|)
   localparam int SUM_W   = DVD_W + 2;          // index + signed quotient
   localparam int DCNT_W  = $clog2(DVD_W + 1);

   // request codes
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LO_RD,
      ST_LO_CAP,
      ST_PR_RD,
      ST_PR_CAP,
      ST_MUL,
      ST_PREP,
      ST_SGN,
      ST_DIV,
      ST_UPD,
      ST_CLAMP,
      ST_DONE
   } state_type;

endpackage

// File: hdl/cis_if.sv
// ----------------------------------------------------------------------------
// cis_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface cis_req_if import cis_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [IDX_W-1:0] entry_index;
   logic [KEY_W-1:0] entry_key;
   logic [KEY_W-1:0] target_key;

   modport source (output valid, req_type, entry_index, entry_key, target_key,
                   input ready);
   modport sink   (input valid, req_type, entry_index, entry_key, target_key,
                   output ready);
endinterface

interface cis_rsp_if import cis_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] found_index;

   modport source (output valid, found_index, input ready);
   modport sink   (input valid, found_index, output ready);
endinterface

// File: hdl/cis_ram.sv
// ----------------------------------------------------------------------------
// cis_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cis_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/cis_div.sv
// ----------------------------------------------------------------------------
// cis_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cis_div import cis_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);

   logic              busy_ff, busy_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    trial;

   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign trial  = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - DCNT_W'(1);
            if (!trial[DVS_W]) begin
               rem_in = trial[DVS_W-1:0];
               quo_in = {quo_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DVS_W-1:0];
               quo_in = {quo_ff[DVD_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = busy_ff && (cnt_ff == '0);

endmodule

// File: hdl/capped_interpolation_search.sv
// A write item goes straight to the RAM, and write items can follow back to back.
// A search loads its result into the output register after its last probe. Each
// probe reads the memory, multiplies and rounds, runs the divider and updates,
// with at most MAX_PROBES probes per search. An empty table skips the probes and
// goes straight to the result. One search runs at a time.
// Reset clears control state and star_count; the key memory is not cleared.
// ----------------------------------------------------------------------------
// capped_interpolation_search
// Sorted key table in a RAM plus a secant search sequencer around it.
// ----------------------------------------------------------------------------
module capped_interpolation_search import cis_pkg::*; #(
   parameter int TABLE_DEPTH = 4096,
   parameter int MAX_PROBES  = 20
) (
   input  logic             clock,
   input  logic             reset,
   cis_req_if.sink          req_chan,
   cis_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int NP_W   = $clog2(MAX_PROBES + 1);
   localparam logic [NP_W-1:0]         NP_MAX = NP_W'(MAX_PROBES);
   localparam logic signed [SUM_W-1:0] S_ONE  = SUM_W'(1);

   // ---------------------------------------------------------------------
   // State and datapath registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [IDX_W-1:0]         star_count_ff;
   logic [IDX_W-1:0]         count_ff, count_in;      // clamped count
   logic [KEY_W-1:0]         tgt_ff, tgt_in;
   logic [IDX_W-1:0]         lo_idx_ff, lo_idx_in;    // previous probe
   logic [IDX_W-1:0]         probe_ff, probe_in;      // current probe
   logic [KEY_W-1:0]         k_lo_ff, k_lo_in;        // key at lo_idx
   logic [NP_W-1:0]          nprobe_ff, nprobe_in;
   logic signed [DIFF_W-1:0]  idiff_ff, idiff_in;
   logic signed [KDIFF_W-1:0] kd_ff, kd_in;
   logic signed [KDIFF_W-1:0] den_ff, den_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [N2_W-1:0]    n2_ff, n2_in;
   logic                      neg_ff, neg_in;
   logic signed [SUM_W-1:0]   qs_ff, qs_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]          found_ff, found_in;

   // ---------------------------------------------------------------------
   // Memory and divider hookup
   // ---------------------------------------------------------------------
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [KEY_W-1:0]  ram_rdata;

   logic             div_start, div_done;
   logic [DVD_W-1:0] div_dvd, div_quo;
   logic [DVS_W-1:0] div_dvs;

   // combinational helpers
   logic                      req_acc;
   logic [IDX_W-1:0]          count_eff;
   logic signed [N2_W-1:0]    n2_abs;
   logic signed [KDIFF_W-1:0] den_abs;
   logic signed [SUM_W-1:0]   q_ext;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   s_count;

   cis_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_chan.entry_key),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   cis_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .done     (div_done)
   );

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign req_acc           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found_index = found_ff;

   // table writes go straight to the RAM; out-of-range positions dropped
   assign ram_we    = req_acc && (req_chan.req_type == REQ_WRITE)
                      && (req_chan.entry_index != '0)
                      && (int'(req_chan.entry_index) <= TABLE_DEPTH);
   assign ram_waddr = ADDR_W'(req_chan.entry_index - IDX_W'(1));

   // count above the memory depth behaves as the full depth
   assign count_eff = (int'(star_count_ff) > TABLE_DEPTH) ?
                      IDX_W'(TABLE_DEPTH) : star_count_ff;

   // absolute values feeding the divider; truncation toward zero is
   // symmetric, so the sign is applied afterwards
   assign n2_abs  = n2_ff[N2_W-1] ? -n2_ff : n2_ff;
   assign den_abs = den_ff[KDIFF_W-1] ? -den_ff : den_ff;
   assign div_dvd = n2_abs[DVD_W-1:0];
   assign div_dvs = {1'b0, den_abs[KDIFF_W-2:0], 1'b0};

   assign q_ext   = $signed({2'b00, div_quo});
   assign sum     = $signed({{(SUM_W-IDX_W){1'b0}}, lo_idx_ff}) + qs_ff;
   assign s_count = $signed({{(SUM_W-IDX_W){1'b0}}, count_ff});

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      tgt_in       = tgt_ff;
      lo_idx_in    = lo_idx_ff;
      probe_in     = probe_ff;
      k_lo_in      = k_lo_ff;
      nprobe_in    = nprobe_ff;
      idiff_in     = idiff_ff;
      kd_in        = kd_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      n2_in        = n2_ff;
      neg_in       = neg_ff;
      qs_in        = qs_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      ram_raddr    = '0;
      div_start    = 1'b0;

      // output register empties on its own handshake
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_chan.req_type == REQ_SEARCH)) begin
               tgt_in    = req_chan.target_key;
               count_in  = count_eff;
               lo_idx_in = IDX_W'(1);
               probe_in  = count_eff;
               nprobe_in = '0;
               if (count_eff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LO_RD;
               end
            end
         end
         ST_LO_RD: begin
            ram_raddr = '0;                  // entry 1
            state_in  = ST_LO_CAP;
         end
         ST_LO_CAP: begin
            k_lo_in  = ram_rdata;
            state_in = ST_PR_RD;
         end
         ST_PR_RD: begin
            // stop on a repeated probe or at the probe cap
            if ((probe_ff != lo_idx_ff) && (nprobe_ff < NP_MAX)) begin
               ram_raddr = ADDR_W'(probe_ff - IDX_W'(1));
               state_in  = ST_PR_CAP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PR_CAP: begin
            if (ram_rdata == k_lo_ff) begin
               state_in = ST_DONE;           // flat segment, no slope
            end else begin
               nprobe_in = nprobe_ff + NP_W'(1);
               idiff_in  = $signed({1'b0, probe_ff}) - $signed({1'b0, lo_idx_ff});
               kd_in     = $signed({1'b0, k_lo_ff}) - $signed({1'b0, tgt_ff});
               den_in    = $signed({1'b0, k_lo_ff}) - $signed({1'b0, ram_rdata});
               k_lo_in   = ram_rdata;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = idiff_ff * kd_ff;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            // round half: (2*num + den) / (2*den)
            n2_in    = $signed({prod_ff[PROD_W-1], prod_ff, 1'b0}) + N2_W'(den_ff);
            state_in = ST_SGN;
         end
         ST_SGN: begin
            neg_in    = n2_ff[N2_W-1] ^ den_ff[KDIFF_W-1];
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            qs_in    = neg_ff ? -q_ext : q_ext;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            lo_idx_in = probe_ff;
            if (sum < S_ONE) begin
               probe_in = IDX_W'(1);
            end else if (sum > s_count) begin
               probe_in = count_ff;
            end else begin
               probe_in = sum[IDX_W-1:0];
            end
            state_in = ST_PR_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               found_in     = probe_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         star_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            star_count_ff <= csr_wdata;
         end
      end
      count_ff  <= count_in;
      tgt_ff    <= tgt_in;
      lo_idx_ff <= lo_idx_in;
      probe_ff  <= probe_in;
      k_lo_ff   <= k_lo_in;
      nprobe_ff <= nprobe_in;
      idiff_ff  <= idiff_in;
      kd_ff     <= kd_in;
      den_ff    <= den_in;
      prod_ff   <= prod_in;
      n2_ff     <= n2_in;
      neg_ff    <= neg_in;
      qs_ff     <= qs_in;
      found_ff  <= found_in;
   end

endmodule

// File: hdl/cis_check.sv
// ----------------------------------------------------------------------------
// cis_check
// Port-level checks for the capped interpolation search block.
// ----------------------------------------------------------------------------
module cis_check import cis_pkg::*; #(
   parameter int TABLE_DEPTH = 4096
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_kind,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [IDX_W-1:0] found_index,
   input logic             csr_we,
   input logic [IDX_W-1:0] csr_wdata
);

   logic [1:0]       pend_ff, pend_in;
   logic [IDX_W-1:0] cnt_ff;
   logic [IDX_W-1:0] lim;
   logic             srch_acc, rsp_acc;

   assign srch_acc = req_valid && req_ready && (req_kind == REQ_SEARCH);
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + {1'b0, srch_acc} - {1'b0, rsp_acc};
   assign lim      = (int'(cnt_ff) > TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         if (csr_we) begin
            cnt_ff <= csr_wdata;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(found_index))
      else $error("result item changed while stalled");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result item without a search");

   a_one_search: assert property (@(posedge clock) disable iff (reset)
      srch_acc |-> pend_ff < 2'd2)
      else $error("search taken while another is still in work");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> found_index <= lim)
      else $error("found index beyond table count");

endmodule

bind capped_interpolation_search cis_check #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_cis_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_kind    (req_chan.req_type),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .found_index (rsp_chan.found_index),
   .csr_we      (csr_we),
   .csr_wdata   (csr_wdata)
);

// File: tb/sv/capped_interpolation_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_interpolation_search_test
// Self-checking bench for the key table and secant search block. A short
// scripted table covers the empty and single-entry tables, the key and index
// extremes, ignored writes, equal keys, unsorted keys and the probe cap. After
// it come random count settings, each with a table fill and a burst of
// searches. Search results are compared against a local model of the search
// or, where a scripted row gives one, against its typed result. Both channels
// idle at random, and the result side holds off for a long stretch once.
// ----------------------------------------------------------------------------
module capped_interpolation_search_test;
   import cis_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int MAX_PROBES  = 20;
   localparam int KEY_MAX     = 129599999;
   localparam int ITEM_GOAL   = 830;

   localparam int SETTLE_CYCLES    = 8;
   localparam int DRAIN_CYCLES     = 16;
   localparam int LONG_HOLD_CYCLES = 3000;
   localparam int TIMEOUT_NS       = 30_000_000;

   localparam logic [KEY_W-1:0] KEY_TOP = 27'd129599999;
   localparam logic [KEY_W-1:0] KEY_MID = 27'd64800000;

   // scripted rows: either a count register write or one item
   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic             rtype;
      logic [IDX_W-1:0] index;    // entry index, or the count value on a CSR row
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] target;
      logic             check;    // use the typed result instead of the model
      logic [IDX_W-1:0] found;
   } script_row_type;

   localparam int SCRIPT_LEN = 27;

   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // empty table after reset answers 0
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   27'd0,     1'b1, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd8191, KEY_TOP, KEY_TOP,   1'b1, 13'd0},
      // smallest and largest keys, one in the middle
      '{ROW_ITEM, REQ_WRITE,  13'd1,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_WRITE,  13'd2,    KEY_TOP, 27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_WRITE,  13'd3,    KEY_MID, 27'd0,     1'b0, 13'd0},
      // out-of-range positions must not land anywhere; an alias onto
      // entry 1 would make it equal entry 2 and show up below
      '{ROW_ITEM, REQ_WRITE,  13'd0,    KEY_TOP, KEY_TOP,   1'b0, 13'd0},
      '{ROW_ITEM, REQ_WRITE,  13'd4097, KEY_TOP, 27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_WRITE,  13'd8191, KEY_TOP, KEY_TOP,   1'b0, 13'd0},
      '{ROW_ITEM, REQ_WRITE,  13'd4096, 27'd1,   27'd0,     1'b0, 13'd0},
      // single entry: answer is 1 without probing
      '{ROW_CSR,  REQ_WRITE,  13'd1,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   27'd12345, 1'b1, 13'd1},
      // two entries; target 0 bounces between them until the probe cap
      '{ROW_CSR,  REQ_WRITE,  13'd2,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   KEY_TOP,   1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   KEY_MID,   1'b0, 13'd0},
      '{ROW_CSR,  REQ_WRITE,  13'd3,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   KEY_MID,   1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   27'd1,     1'b0, 13'd0},
      // last entry equals the first: search stops on the first compare
      '{ROW_ITEM, REQ_WRITE,  13'd4,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_CSR,  REQ_WRITE,  13'd4,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   27'd100,   1'b0, 13'd0},
      // unsorted tail
      '{ROW_ITEM, REQ_WRITE,  13'd5,    27'd10,  27'd0,     1'b0, 13'd0},
      '{ROW_CSR,  REQ_WRITE,  13'd5,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   27'd70000000, 1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   27'd5,     1'b0, 13'd0},
      // count back to zero
      '{ROW_CSR,  REQ_WRITE,  13'd0,    27'd0,   27'd0,     1'b0, 13'd0},
      '{ROW_ITEM, REQ_SEARCH, 13'd0,    27'd0,   KEY_MID,   1'b1, 13'd0}
   };

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [IDX_W-1:0] csr_wdata;

   cis_req_if req_if ();
   cis_rsp_if rsp_if ();

   capped_interpolation_search u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block: key table, which entries hold data, count register
   bit [KEY_W-1:0]   key_store   [TABLE_DEPTH];
   bit               key_written [TABLE_DEPTH];
   logic [IDX_W-1:0] count_shadow;

   logic [IDX_W-1:0] found_index_queue [$];

   int  error_count      = 0;
   int  items_sent       = 0;
   int  writes_sent      = 0;
   int  searches_sent    = 0;
   int  results_checked  = 0;
   int  settings_applied = 0;
   int  long_holds       = 0;
   bit  long_hold_pending = 1'b0;
   bit  no_gaps           = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Timeout with %0d results outstanding", found_index_queue.size());
      $display("Test completed with failures");
      $finish;
   end

   // Secant search over the shadow table. Returns 0 when the search would
   // touch an entry that was never written, so such a search is not sent.
   function automatic bit predict_found_index(input logic [KEY_W-1:0] target,
                                              output logic [IDX_W-1:0] found);
      longint cnt, lo, probe, nxt, k_lo, k_pr, tgt, num, den, n2, d2;
      int     probes;
      bit     safe;
      safe   = 1'b1;
      probes = 0;
      found  = '0;
      tgt    = longint'(target);
      cnt    = longint'(count_shadow);
      if (cnt > TABLE_DEPTH)
         cnt = TABLE_DEPTH;
      if (cnt < 1)
         return safe;
      lo    = 1;
      safe &= key_written[0];
      k_lo  = longint'(key_store[0]);
      probe = cnt;
      while (probe != lo && probes < MAX_PROBES) begin
         safe &= key_written[probe-1];
         k_pr  = longint'(key_store[probe-1]);
         if (k_pr == k_lo)
            break;
         probes++;
         // round half up of num/den, truncated toward zero, in exact integers
         num = (probe - lo) * (k_lo - tgt);
         den = k_lo - k_pr;
         n2  = 2 * num + den;
         d2  = 2 * den;
         if (d2 < 0) begin
            n2 = -n2;
            d2 = -d2;
         end
         nxt   = lo + n2 / d2;
         k_lo  = k_pr;
         lo    = probe;
         probe = nxt;
         if (probe < 1)
            probe = 1;
         if (probe > cnt)
            probe = cnt;
         if (probe == lo)
            break;
      end
      found = probe[IDX_W-1:0];
      return safe;
   endfunction

   // idle length: mostly short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(99, 0);
      if (r < 80)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Offer one item, wait for it to be taken, then update the shadow.
   // Valid stays high on return; a CSR write or an idle gap in the next call drops it.
   task automatic send_item(input logic rtype, input logic [IDX_W-1:0] index,
                            input logic [KEY_W-1:0] key,
                            input logic [KEY_W-1:0] target,
                            input bit check = 1'b0,
                            input logic [IDX_W-1:0] expected = '0);
      int               gap;
      logic [IDX_W-1:0] predicted;
      gap = (no_gaps || $urandom_range(9, 0) < 5) ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= rtype;
      req_if.entry_index <= index;
      req_if.entry_key   <= key;
      req_if.target_key  <= target;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      items_sent++;
      if (rtype == REQ_WRITE) begin
         writes_sent++;
         // positions 0 and above the depth are dropped by the block
         if (index >= 1 && index <= TABLE_DEPTH) begin
            key_store[index-1]   = key;
            key_written[index-1] = 1'b1;
         end
      end else begin
         void'(predict_found_index(target, predicted));
         found_index_queue.push_back(check ? expected : predicted);
         searches_sent++;
      end
   endtask

   // count register is only touched with the block drained
   task automatic set_star_count(input logic [IDX_W-1:0] value);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (found_index_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      count_shadow = value;
      settings_applied++;
   endtask

   task automatic try_search(input logic [KEY_W-1:0] tgt, output bit sent);
      logic [IDX_W-1:0] unused;
      sent = predict_found_index(tgt, unused);
      if (sent)
         send_item(REQ_SEARCH, IDX_W'($urandom_range(8191, 0)),
                   KEY_W'($urandom_range(KEY_MAX, 0)), tgt);
   endtask

   // target mostly an existing key or close to one, else anywhere
   task automatic random_search(input int n);
      int r, t;
      bit sent;
      sent = 1'b0;
      for (int tries = 0; tries < 8 && !sent; tries++) begin
         r = $urandom_range(9, 0);
         if (n > 0 && r < 5) begin
            t = int'(key_store[$urandom_range(n - 1, 0)]);
         end else if (n > 0 && r < 7) begin
            t = int'(key_store[$urandom_range(n - 1, 0)]);
            t = t + int'($urandom_range(100, 0)) - 50;
            if (t < 0)
               t = 0;
            if (t > KEY_MAX)
               t = KEY_MAX;
         end else begin
            t = $urandom_range(KEY_MAX, 0);
         end
         try_search(KEY_W'(t), sent);
      end
   endtask

   // load entries 1..n: mostly ascending, sometimes dense with repeats,
   // sometimes in no order at all
   task automatic fill_table(input int n);
      int          style;
      int unsigned k, step_max;
      style    = $urandom_range(9, 0);
      k        = (style < 2) ? 0 : $urandom_range(KEY_MAX / 2, 0);
      step_max = (KEY_MAX - k) / n;
      if (style == 2)
         step_max = 2;
      for (int i = 1; i <= n; i++) begin
         if (style == 9)
            k = $urandom_range(KEY_MAX, 0);
         else
            k = k + $urandom_range(step_max, 0);
         send_item(REQ_WRITE, IDX_W'(i), KEY_W'(k), KEY_W'($urandom_range(KEY_MAX, 0)));
      end
   endtask

   // Result side. Random stalls with calm stretches in between; on request
   // one long hold-off so that finished searches back up into the input.
   initial begin : result_side
      int stall_left, calm_left;
      bit calm;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            long_hold_pending = 1'b0;
            long_holds++;
         end else begin
            if (calm_left == 0) begin
               calm      = ($urandom_range(3, 0) == 0);
               calm_left = $urandom_range(400, 100);
            end
            calm_left--;
            if (stall_left > 0) begin
               rsp_if.ready <= 1'b0;
               stall_left--;
            end else if (!calm && $urandom_range(9, 0) < 3) begin
               rsp_if.ready <= 1'b0;
               stall_left = idle_length() - 1;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // result checker: oldest expectation first
   always @(posedge clock) begin
      logic [IDX_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (found_index_queue.size() == 0) begin
            $error("found_index: no result expected, actual %0d", rsp_if.found_index);
            error_count++;
         end else begin
            want = found_index_queue.pop_front();
            if (rsp_if.found_index !== want) begin
               $error("found_index mismatch: expected %0d, actual %0d",
                      want, rsp_if.found_index);
               error_count++;
            end
            results_checked++;
         end
      end
   end

   initial begin : stimulus
      int          phase, count, m, r, big_idx;
      int unsigned step_b;
      int unsigned marks [5];
      bit          sent;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_WRITE;
      req_if.entry_index = '0;
      req_if.entry_key   = '0;
      req_if.target_key  = '0;
      count_shadow       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // scripted corner cases
      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_CSR)
            set_star_count(SCRIPT[i].index);
         else
            send_item(SCRIPT[i].rtype, SCRIPT[i].index, SCRIPT[i].key,
                      SCRIPT[i].target, SCRIPT[i].check, SCRIPT[i].found);
      end

      // random phases: new count, fresh table, burst of searches
      phase   = 0;
      big_idx = 0;
      while (items_sent < ITEM_GOAL) begin
         no_gaps = (phase % 4 == 1);
         if (phase % 6 == 3) begin
            // Full-depth count. Keys are linear in the index at entry 1,
            // entry 4096 and a few marks, so a search aimed at a mark
            // only touches those. Every third time entry 4096 repeats
            // entry 1 and the search stops at once.
            case (big_idx % 3)
               0: set_star_count(IDX_W'(TABLE_DEPTH));
               1: set_star_count(13'd8191);
               default: set_star_count(IDX_W'($urandom_range(8190, TABLE_DEPTH + 1)));
            endcase
            step_b = $urandom_range(31000, 20000);
            send_item(REQ_WRITE, IDX_W'(1), KEY_W'(step_b),
                      KEY_W'($urandom_range(KEY_MAX, 0)));
            send_item(REQ_WRITE, IDX_W'(TABLE_DEPTH),
                      KEY_W'((big_idx % 3 == 2) ? step_b : step_b * TABLE_DEPTH),
                      KEY_W'($urandom_range(KEY_MAX, 0)));
            foreach (marks[j]) begin
               marks[j] = $urandom_range(TABLE_DEPTH - 1, 2);
               send_item(REQ_WRITE, IDX_W'(marks[j]), KEY_W'(step_b * marks[j]),
                         KEY_W'($urandom_range(KEY_MAX, 0)));
            end
            foreach (marks[j])
               try_search(KEY_W'(step_b * marks[j]), sent);
            try_search(KEY_W'(step_b), sent);
            try_search(KEY_W'(step_b * TABLE_DEPTH), sent);
            repeat (3) random_search(TABLE_DEPTH);
            big_idx++;
         end else begin
            r = $urandom_range(99, 0);
            if (r < 6)
               count = 0;
            else if (r < 16)
               count = $urandom_range(3, 1);
            else if (r < 88)
               count = $urandom_range(40, 4);
            else
               count = $urandom_range(160, 41);
            set_star_count(IDX_W'(count));
            if (count > 0)
               fill_table(count);
            if (phase == 2)
               long_hold_pending = 1'b1;
            m = (phase == 2) ? 12 : $urandom_range(10, 3);
            repeat (m) begin
               // some noise: dropped writes and rewrites that break the order
               r = $urandom_range(99, 0);
               if (r < 8)
                  send_item(REQ_WRITE,
                            IDX_W'(($urandom_range(1, 0) == 0) ? 0 :
                                   $urandom_range(8191, 4097)),
                            KEY_W'($urandom_range(KEY_MAX, 0)),
                            KEY_W'($urandom_range(KEY_MAX, 0)));
               else if (r < 15 && count > 0)
                  send_item(REQ_WRITE, IDX_W'($urandom_range(count, 1)),
                            KEY_W'($urandom_range(KEY_MAX, 0)),
                            KEY_W'($urandom_range(KEY_MAX, 0)));
               random_search(count);
            end
         end
         phase++;
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (found_index_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d table writes, %0d searches, %0d count settings",
               items_sent, writes_sent, searches_sent, settings_applied);
      $display("Checked %0d results, %0d long result hold-off(s), %0d error(s)",
               results_checked, long_holds, error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
hdl/cis_pkg.sv
hdl/cis_if.sv
hdl/cis_ram.sv
hdl/cis_div.sv
hdl/capped_interpolation_search.sv
hdl/cis_check.sv
tb/sv/capped_interpolation_search_test.sv
